[design/fbm_pkg.sv]
// shared constants, types and the gradient helper of the fbm noise sampler
// no dependencies; used by the channel interfaces and the top level
package fbm_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int ONE             = 1 << FRAC_BITS;
  localparam int TABLE_SIZE      = 256;
  localparam int IDX_W           = $clog2(TABLE_SIZE);
  localparam int MAX_OCTAVES_DEF = 8;

  localparam int COORD_W  = 24;
  localparam int NOISE_W  = 18;
  localparam int HEIGHT_W = 19;
  localparam int OCT_W    = 4;
  localparam int SEED_W   = 32;
  localparam int GAIN_W   = 16;
  localparam int CFG_DW   = 32;
  localparam int CFG_IW   = 2;

  typedef enum logic [CFG_IW-1:0] {
    CFG_OCTAVES = 2'd0,
    CFG_SEED    = 2'd1,
    CFG_GAIN    = 2'd2
  } cfg_idx_e;

  localparam logic ACT_REBUILD = 1'b1;

  localparam logic [OCT_W-1:0]  OCT_RST  = 4'd5;
  localparam logic [SEED_W-1:0] SEED_RST = 32'd1337;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd6400;
  localparam logic [SEED_W-1:0] SEED_ALT = 32'hdeadbeef;
  localparam logic [SEED_W-1:0] LCG_MUL  = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_INC  = 32'd1013904223;

  typedef logic signed [19:0] grad_t;

  // diagonal gradient: hash bit 0 picks +dx, bit 1 picks +dy
  function automatic grad_t grad(input logic [1:0] h, input logic signed [16:0] dx,
                                 input logic signed [16:0] dy);
    grad_t u;
    grad_t v;
    u = h[0] ? grad_t'(dx) : -grad_t'(dx);
    v = h[1] ? grad_t'(dy) : -grad_t'(dy);
    return u + v;
  endfunction

endpackage

[design/fbm_in_if.sv]
// input channel of the fbm noise sampler: valid, ready and one request item
// depends on fbm_pkg for field widths
interface fbm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [fbm_pkg::COORD_W-1:0] x_coord;
  logic [fbm_pkg::COORD_W-1:0] y_coord;

  modport source (output valid, action, x_coord, y_coord, input ready);
  modport sink   (input valid, action, x_coord, y_coord, output ready);
endinterface

[design/fbm_out_if.sv]
// result channel of the fbm noise sampler: valid, ready and one result item
// depends on fbm_pkg for field widths
interface fbm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fbm_pkg::NOISE_W-1:0]  noise_value;
  logic signed [fbm_pkg::HEIGHT_W-1:0] height_value;

  modport source (output valid, noise_value, height_value, input ready);
  modport sink   (input valid, noise_value, height_value, output ready);
endinterface

[design/fbm_gradient_noise_sampler.sv]
// fractal gradient noise sampler with permutation table rebuild
// depends on fbm_pkg, fbm_in_if and fbm_out_if
//
//  channel   dir  handshake          payload
//  req_i     in   valid/ready        action, x_coord, y_coord
//  rsp_o     out  valid/ready        noise_value, height_value
//  cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (no read-back)
//
// sample: after entry, each octave steps through fade of x, fade of y and bilinear
//   blend on one shared 21x18 multiplier, then height scaling and hand-off follow
// rebuild: 255 swaps, each paced by the one-bit-a-cycle remainder unit and
//   the single read port of the table
// req_i.ready is high only in idle; a result waiting in the output register
//   does not block the next item until that item's own result is ready
// reset: table reads as identity through per-entry valid bits; control and config
//   registers take their defaults at once
module fbm_gradient_noise_sampler #(
  parameter int MAX_OCTAVES = fbm_pkg::MAX_OCTAVES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fbm_in_if.sink                      req_i,
  fbm_out_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [fbm_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [fbm_pkg::CFG_DW-1:0]  cfg_data_i
);
  import fbm_pkg::*;

  localparam int CNT_W = $clog2(MAX_OCTAVES + 1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_OCT    = 10'b0000000010,
    ST_HGT    = 10'b0000000100,
    ST_OUT    = 10'b0000001000,
    ST_RB_LCG = 10'b0000010000,
    ST_RB_DIV = 10'b0000100000,
    ST_RB_RDI = 10'b0001000000,
    ST_RB_RDJ = 10'b0010000000,
    ST_RB_WRI = 10'b0100000000,
    ST_RB_WRJ = 10'b1000000000
  } state_e;

  // configuration registers
  logic [OCT_W-1:0]  oct_cfg_q;
  logic [SEED_W-1:0] seed_q;
  logic [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_cfg_q <= OCT_RST;
      seed_q    <= SEED_RST;
      gain_q    <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OCTAVES: oct_cfg_q <= cfg_data_i[OCT_W-1:0];
        CFG_SEED:    seed_q    <= cfg_data_i[SEED_W-1:0];
        CFG_GAIN:    gain_q    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  state_e           state_q, state_d;
  logic [4:0]       step_q, step_d;
  logic [CNT_W-1:0] oct_q, oct_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // sample datapath
  logic [COORD_W-1:0]       xs_q, xs_d, ys_q, ys_d;
  logic [19:0]              w_q, w_d;
  logic signed [21:0]       prod_q, prod_d;
  logic [16:0]              u_q, u_d, v_q, v_d;
  logic [IDX_W-1:0]         hx0_q, hx0_d, hx1_q, hx1_d;
  logic [IDX_W-1:0]         h00_q, h00_d, h01_q, h01_d, h10_q, h10_d, h11_q, h11_d;
  logic signed [19:0]       d_q, d_d, r0_q, r0_d, r1_q, r1_d, p_q, p_d;
  logic signed [20:0]       acc_q, acc_d;
  logic signed [NOISE_W-1:0] sat_q, sat_d;

  // rebuild datapath
  logic [SEED_W-1:0] lcg_q, lcg_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [8:0]        rem_q, rem_d;
  logic [4:0]        bit_q, bit_d;
  logic [IDX_W-1:0]  pi_q, pi_d;

  // result holding and output register
  logic signed [NOISE_W-1:0]  res_noise_q, res_noise_d;
  logic signed [HEIGHT_W-1:0] res_height_q, res_height_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [NOISE_W-1:0]  out_noise_q;
  logic signed [HEIGHT_W-1:0] out_height_q;
  logic                       out_load;

  // permutation table: memory, registered read, valid bits for identity
  logic [IDX_W-1:0]      perm_mem_q [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] pvld_q;
  logic                  pvld_clr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr, wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      rd_data_q, rd_addr_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      perm_rd;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      perm_mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= perm_mem_q[rd_addr];
    rd_addr_q <= rd_addr;
    rd_vld_q  <= pvld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= '0;
    end else if (pvld_clr) begin
      pvld_q <= '0;
    end else if (wr_en) begin
      pvld_q[wr_addr] <= 1'b1;
    end
  end

  // an entry never written since reset or rebuild reads as its own index
  assign perm_rd = rd_vld_q ? rd_data_q : rd_addr_q;

  // shared multiplier: signed operand times unsigned fraction, floor by 2^F
  logic                mul_en;
  logic signed [20:0]  a_op;
  logic [16:0]         b_op;
  logic signed [38:0]  mul_full;

  assign mul_full = a_op * $signed({1'b0, b_op});
  assign prod_d   = mul_en ? mul_full[FRAC_BITS+21:FRAC_BITS] : prod_q;

  // lattice fractions and corner gradients of the current octave
  logic [FRAC_BITS-1:0]  fx, fy;
  logic [IDX_W-1:0]      cx0, cy0;
  logic signed [16:0]    fx_s, fy_s, gx_s, gy_s;
  grad_t                 g00, g01, g10, g11;
  logic signed [21:0]    w10;
  logic [8:0]            div_v;
  logic [9:0]            trial;
  logic [IDX_W-1:0]      jdx;
  logic                  in_acc;
  logic [CNT_W-1:0]      oct_nx;

  assign fx   = xs_q[FRAC_BITS-1:0];
  assign fy   = ys_q[FRAC_BITS-1:0];
  assign cx0  = xs_q[FRAC_BITS+IDX_W-1:FRAC_BITS];
  assign cy0  = ys_q[FRAC_BITS+IDX_W-1:FRAC_BITS];
  assign fx_s = $signed({1'b0, fx});
  assign fy_s = $signed({1'b0, fy});
  assign gx_s = $signed({1'b1, fx});  // fx minus one
  assign gy_s = $signed({1'b1, fy});
  assign g00  = grad(h00_q[1:0], fx_s, fy_s);
  assign g10  = grad(h10_q[1:0], gx_s, fy_s);
  assign g01  = grad(h01_q[1:0], fx_s, gy_s);
  assign g11  = grad(h11_q[1:0], gx_s, gy_s);
  assign w10  = 22'(10 * ONE) - prod_q;

  assign div_v  = {1'b0, idx_q} + 9'd1;
  assign trial  = {rem_q, lcg_q[bit_q]};
  assign jdx    = rem_q[IDX_W-1:0];
  assign oct_nx = oct_q + CNT_W'(1);

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    oct_d        = oct_q;
    cnt_d        = cnt_q;
    xs_d         = xs_q;
    ys_d         = ys_q;
    w_d          = w_q;
    u_d          = u_q;
    v_d          = v_q;
    hx0_d        = hx0_q;
    hx1_d        = hx1_q;
    h00_d        = h00_q;
    h01_d        = h01_q;
    h10_d        = h10_q;
    h11_d        = h11_q;
    d_d          = d_q;
    r0_d         = r0_q;
    r1_d         = r1_q;
    p_d          = p_q;
    acc_d        = acc_q;
    sat_d        = sat_q;
    lcg_d        = lcg_q;
    idx_d        = idx_q;
    rem_d        = rem_q;
    bit_d        = bit_q;
    pi_d         = pi_q;
    res_noise_d  = res_noise_q;
    res_height_d = res_height_q;
    mul_en       = 1'b0;
    a_op         = '0;
    b_op         = '0;
    rd_addr      = cx0;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = perm_rd;
    pvld_clr     = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_i.action == ACT_REBUILD) begin
            lcg_d    = (seed_q == '0) ? SEED_ALT : seed_q;
            idx_d    = IDX_W'(TABLE_SIZE - 1);
            pvld_clr = 1'b1;
            state_d  = ST_RB_LCG;
          end else begin
            xs_d   = req_i.x_coord;
            ys_d   = req_i.y_coord;
            acc_d  = '0;
            oct_d  = '0;
            step_d = '0;
            cnt_d  = (int'(oct_cfg_q) > MAX_OCTAVES) ? CNT_W'(MAX_OCTAVES)
                                                     : CNT_W'(oct_cfg_q);
            state_d = (oct_cfg_q == '0) ? ST_HGT : ST_OCT;
          end
        end
      end

      ST_OCT: begin
        step_d = step_q + 5'd1;
        unique case (step_q)
          // fade of fx: corner hash reads run alongside
          5'd0: begin
            w_d     = 20'(15 * ONE) - ({4'b0, fx} * 20'd6);
            rd_addr = cx0;
          end
          5'd1: begin
            mul_en  = 1'b1;
            a_op    = $signed({1'b0, w_q});
            b_op    = {1'b0, fx};
            hx0_d   = perm_rd;
            rd_addr = cx0 + IDX_W'(1);
          end
          5'd2: begin
            w_d     = w10[19:0];
            hx1_d   = perm_rd;
            rd_addr = hx0_q + cy0;
          end
          5'd3: begin
            mul_en  = 1'b1;
            a_op    = $signed({1'b0, w_q});
            b_op    = {1'b0, fx};
            h00_d   = perm_rd;
            rd_addr = hx0_q + cy0 + IDX_W'(1);
          end
          5'd4, 5'd5: begin
            mul_en = 1'b1;
            a_op   = prod_q[20:0];
            b_op   = {1'b0, fx};
            if (step_q == 5'd4) begin
              h01_d   = perm_rd;
              rd_addr = hx1_q + cy0;
            end else begin
              h10_d   = perm_rd;
              rd_addr = hx1_q + cy0 + IDX_W'(1);
            end
          end
          // fade of fy
          5'd6: begin
            u_d   = prod_q[16:0];
            h11_d = perm_rd;
            w_d   = 20'(15 * ONE) - ({4'b0, fy} * 20'd6);
          end
          5'd7, 5'd9: begin
            mul_en = 1'b1;
            a_op   = $signed({1'b0, w_q});
            b_op   = {1'b0, fy};
          end
          5'd8: begin
            w_d = w10[19:0];
          end
          5'd10, 5'd11: begin
            mul_en = 1'b1;
            a_op   = prod_q[20:0];
            b_op   = {1'b0, fy};
          end
          // bilinear blend
          5'd12: begin
            v_d = prod_q[16:0];
            d_d = g10 - g00;
          end
          5'd13: begin
            mul_en = 1'b1;
            a_op   = 21'(d_q);
            b_op   = u_q;
            d_d    = g11 - g01;
          end
          5'd14: begin
            mul_en = 1'b1;
            a_op   = 21'(d_q);
            b_op   = u_q;
            r0_d   = g00 + prod_q[19:0];
          end
          5'd15: begin
            r1_d = g01 + prod_q[19:0];
          end
          5'd16: begin
            d_d = r1_q - r0_q;
          end
          5'd17: begin
            mul_en = 1'b1;
            a_op   = 21'(d_q);
            b_op   = v_q;
          end
          5'd18: begin
            p_d = r0_q + prod_q[19:0];
          end
          5'd19: begin
            // amplitude halves each octave: arithmetic shift floors
            acc_d  = acc_q + 21'(p_q >>> oct_nx);
            step_d = '0;
            if (oct_nx == cnt_q) begin
              state_d = ST_HGT;
            end else begin
              oct_d = oct_nx;
              xs_d  = {xs_q[COORD_W-2:0], 1'b0};
              ys_d  = {ys_q[COORD_W-2:0], 1'b0};
            end
          end
          default: ;
        endcase
      end

      ST_HGT: begin
        step_d = step_q + 5'd1;
        priority case (step_q)
          5'd0: begin
            if (acc_q > 21'sd131071) begin
              sat_d = 18'sh1ffff;
            end else if (acc_q < -21'sd131072) begin
              sat_d = 18'sh20000;
            end else begin
              sat_d = acc_q[NOISE_W-1:0];
            end
          end
          5'd1: begin
            mul_en = 1'b1;
            a_op   = 21'(sat_q);
            b_op   = {1'b0, gain_q};
          end
          default: begin
            res_noise_d = sat_q;
            if (prod_q > 22'sd262143) begin
              res_height_d = 19'sh3ffff;
            end else if (prod_q < -22'sd262144) begin
              res_height_d = 19'sh40000;
            end else begin
              res_height_d = prod_q[HEIGHT_W-1:0];
            end
            step_d  = '0;
            state_d = ST_OUT;
          end
        endcase
      end

      ST_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      // fisher-yates: one lcg step, remainder by idx+1, then swap
      ST_RB_LCG: begin
        lcg_d   = lcg_q * LCG_MUL + LCG_INC;
        rem_d   = '0;
        bit_d   = 5'd31;
        state_d = ST_RB_DIV;
      end

      ST_RB_DIV: begin
        if (trial >= {1'b0, div_v}) begin
          rem_d = 9'(trial - {1'b0, div_v});
        end else begin
          rem_d = trial[8:0];
        end
        bit_d = bit_q - 5'd1;
        if (bit_q == '0) begin
          state_d = ST_RB_RDI;
        end
      end

      ST_RB_RDI: begin
        rd_addr = idx_q;
        state_d = ST_RB_RDJ;
      end

      ST_RB_RDJ: begin
        pi_d    = perm_rd;
        rd_addr = jdx;
        state_d = ST_RB_WRI;
      end

      ST_RB_WRI: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = perm_rd;
        state_d = ST_RB_WRJ;
      end

      ST_RB_WRJ: begin
        wr_en   = 1'b1;
        wr_addr = jdx;
        wr_data = pi_q;
        if (idx_q == IDX_W'(1)) begin
          res_noise_d  = '0;
          res_height_d = '0;
          state_d      = ST_OUT;
        end else begin
          idx_d   = idx_q - IDX_W'(1);
          state_d = ST_RB_LCG;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      oct_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      oct_q       <= oct_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    xs_q         <= xs_d;
    ys_q         <= ys_d;
    w_q          <= w_d;
    prod_q       <= prod_d;
    u_q          <= u_d;
    v_q          <= v_d;
    hx0_q        <= hx0_d;
    hx1_q        <= hx1_d;
    h00_q        <= h00_d;
    h01_q        <= h01_d;
    h10_q        <= h10_d;
    h11_q        <= h11_d;
    d_q          <= d_d;
    r0_q         <= r0_d;
    r1_q         <= r1_d;
    p_q          <= p_d;
    acc_q        <= acc_d;
    sat_q        <= sat_d;
    lcg_q        <= lcg_d;
    rem_q        <= rem_d;
    pi_q         <= pi_d;
    res_noise_q  <= res_noise_d;
    res_height_q <= res_height_d;
    if (out_load) begin
      out_noise_q  <= res_noise_q;
      out_height_q <= res_height_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.noise_value  = out_noise_q;
  assign rsp_o.height_value = out_height_q;

`ifndef SYNTHESIS
  // swap index from the remainder unit stays below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RB_RDI) |-> (rem_q < div_v))
    else $error("remainder not below divisor");

  // octave counter never reaches the clamped octave count while working
  a_oct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OCT) |-> (oct_q < cnt_q))
    else $error("octave counter out of range");

  // the fade weight of x lies in zero to one
  a_fade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OCT && step_q == 5'd6) |-> (prod_q >= 0 && prod_q <= 22'(ONE)))
    else $error("fade weight out of range");

  // a result item appears only from the hand-off state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result valid without hand-off");

  // the shuffle index never reaches zero inside a rebuild
  a_idx_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RB_LCG || state_q == ST_RB_DIV || state_q == ST_RB_WRJ) |->
    (idx_q != '0))
    else $error("shuffle index reached zero");
`endif

endmodule
